// ===== rtl/sdw_pkg.sv =====
package sdw_pkg;

   localparam int WINDOW_BITS_DEFAULT = 1024;
   localparam int SEQ_W               = 32;
   localparam int BIT_IDX_W           = 6;
   localparam int WORD_W              = 64;
   localparam int BLK_W               = SEQ_W - BIT_IDX_W;
   localparam int REQ_TDATA_W         = 32;
   localparam int RSP_TDATA_W         = 8;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT    = 2'd0,
      VERDICT_DUPLICATE = 2'd1,
      VERDICT_TOO_OLD   = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

   // single bit of a bitmap word
   function automatic logic [WORD_W-1:0] onehot_mask(input logic [BIT_IDX_W-1:0] idx);
      onehot_mask = {{(WORD_W-1){1'b0}}, 1'b1} << idx;
   endfunction

   // bits strictly above idx
   function automatic logic [WORD_W-1:0] above_mask(input logic [BIT_IDX_W-1:0] idx);
      above_mask = ({WORD_W{1'b1}} << idx) << 1;
   endfunction

   // bits from 0 up to and including idx
   function automatic logic [WORD_W-1:0] upto_mask(input logic [BIT_IDX_W-1:0] idx);
      upto_mask = ~(({WORD_W{1'b1}} << idx) << 1);
   endfunction

endpackage

// ===== rtl/sequence_dedup_window_unit.sv =====
// Channel  | Dir | Ports                        | Contents
// ---------+-----+------------------------------+-----------------------------------------
// request  | in  | req_tvalid/tready/tdata[31:0] | seq_number (32b, unsigned, wrapping)
// response | out | rsp_tvalid/tready/tdata[7:0]  | verdict (2b): 0 accept, 1 dup, 2 too old
//
// Per request: equal or too old goes straight to the verdict; behind within the window
// reads and writes back one bitmap word; advance by less than a window reads and writes
// back each bitmap word from the old top word through the new top word; a jump of a
// window or more rewrites all WINDOW_BITS/64 words. The single RAM port pair does each.
// After reset a clearing pass writes zeros to all WINDOW_BITS/64 words; req_tready
// stays low for those cycles. One request is in flight at a time; a finished
// verdict waits in the output register while the next request is accepted.
module sequence_dedup_window_unit #(
   parameter int WINDOW_BITS = sdw_pkg::WINDOW_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sdw_pkg::REQ_TDATA_W-1:0] req_tdata,   // [31:0] seq_number
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sdw_pkg::RSP_TDATA_W-1:0] rsp_tdata    // [1:0] verdict, [7:2] zero
);

   localparam int WORDS  = WINDOW_BITS / sdw_pkg::WORD_W;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
   localparam logic [sdw_pkg::SEQ_W-1:0] WIN = sdw_pkg::SEQ_W'(WINDOW_BITS);

   // ring slot of a 64-sequence block
   function automatic logic [ADDR_W-1:0] slot_of(input logic [sdw_pkg::BLK_W-1:0] blk);
      slot_of = ADDR_W'(blk % WORDS);
   endfunction

   sdw_pkg::state_type   state_ff, state_in;
   logic                 started_ff, started_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic                 jump_ff, jump_in;

   logic [sdw_pkg::SEQ_W-1:0]     top_ff, top_in;
   logic [sdw_pkg::SEQ_W-1:0]     seq_ff, seq_in;
   logic [sdw_pkg::BLK_W-1:0]     cur_ff, cur_in;      // block being rewritten
   logic [sdw_pkg::BIT_IDX_W-1:0] tb_ff, tb_in;        // old top bit index
   logic                          adv_ff, adv_in;      // advance vs. in-window check
   logic                          first_ff, first_in;  // on the old top's word
   sdw_pkg::verdict_type          verdict_ff, verdict_in;
   sdw_pkg::verdict_type          rsp_verdict_ff, rsp_verdict_in;

   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [sdw_pkg::WORD_W-1:0]    ram_wr_data;
   logic                          ram_rd_en;
   logic [ADDR_W-1:0]             ram_rd_addr;
   logic [sdw_pkg::WORD_W-1:0]    ram_rd_data;

   logic [sdw_pkg::SEQ_W-1:0]     req_seq;
   logic [sdw_pkg::SEQ_W-1:0]     ahead;
   logic [sdw_pkg::SEQ_W-1:0]     back;
   logic [sdw_pkg::WORD_W-1:0]    clr_mask;
   logic [sdw_pkg::WORD_W-1:0]    set_mask;
   logic                          hit;
   logic                          last_word;

   assign req_seq   = req_tdata[sdw_pkg::SEQ_W-1:0];
   assign ahead     = req_seq - top_ff;
   assign back      = top_ff - req_seq;
   assign hit       = ram_rd_data[seq_ff[sdw_pkg::BIT_IDX_W-1:0]];
   assign last_word = (cur_ff == seq_ff[sdw_pkg::SEQ_W-1:sdw_pkg::BIT_IDX_W]);

   // clear the passed sequences of this word, then set the new one
   always_comb begin
      clr_mask = '0;
      set_mask = '0;
      if (adv_ff) begin
         clr_mask = {sdw_pkg::WORD_W{1'b1}};
         if (first_ff) begin
            clr_mask = clr_mask & sdw_pkg::above_mask(tb_ff);
         end
         if (last_word) begin
            clr_mask = clr_mask & sdw_pkg::upto_mask(seq_ff[sdw_pkg::BIT_IDX_W-1:0]);
         end
      end
      if (last_word) begin
         set_mask = sdw_pkg::onehot_mask(seq_ff[sdw_pkg::BIT_IDX_W-1:0]);
      end
   end

   always_comb begin
      state_in       = state_ff;
      started_in     = started_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_verdict_in = rsp_verdict_ff;
      sweep_in       = sweep_ff;
      jump_in        = jump_ff;
      top_in         = top_ff;
      seq_in         = seq_ff;
      cur_in         = cur_ff;
      tb_in          = tb_ff;
      adv_in         = adv_ff;
      first_in       = first_ff;
      verdict_in     = verdict_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = slot_of(cur_ff);
      ram_wr_data    = (ram_rd_data & ~clr_mask) | set_mask;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = slot_of(cur_ff);

      case (state_ff)
         sdw_pkg::ST_CLEAR: begin
            // reset pass, or whole-window clear on a large jump
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            if (jump_ff &&
                sweep_ff == slot_of(seq_ff[sdw_pkg::SEQ_W-1:sdw_pkg::BIT_IDX_W])) begin
               ram_wr_data = sdw_pkg::onehot_mask(seq_ff[sdw_pkg::BIT_IDX_W-1:0]);
            end
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               jump_in  = 1'b0;
               if (jump_ff) begin
                  verdict_in = sdw_pkg::VERDICT_ACCEPT;
                  state_in   = sdw_pkg::ST_DONE;
               end else begin
                  state_in = sdw_pkg::ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         sdw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               seq_in = req_seq;
               if (!started_ff) begin
                  // first request: bitmap is clean, just set its bit
                  started_in = 1'b1;
                  top_in     = req_seq;
                  adv_in     = 1'b0;
                  cur_in     = req_seq[sdw_pkg::SEQ_W-1:sdw_pkg::BIT_IDX_W];
                  state_in   = sdw_pkg::ST_READ;
               end else if (ahead == '0) begin
                  verdict_in = sdw_pkg::VERDICT_DUPLICATE;
                  state_in   = sdw_pkg::ST_DONE;
               end else if (!ahead[sdw_pkg::SEQ_W-1]) begin
                  top_in = req_seq;
                  if (ahead >= WIN) begin
                     jump_in  = 1'b1;
                     state_in = sdw_pkg::ST_CLEAR;
                  end else begin
                     adv_in   = 1'b1;
                     first_in = 1'b1;
                     tb_in    = top_ff[sdw_pkg::BIT_IDX_W-1:0];
                     cur_in   = top_ff[sdw_pkg::SEQ_W-1:sdw_pkg::BIT_IDX_W];
                     state_in = sdw_pkg::ST_READ;
                  end
               end else if (back >= WIN) begin
                  // includes the half-space distance
                  verdict_in = sdw_pkg::VERDICT_TOO_OLD;
                  state_in   = sdw_pkg::ST_DONE;
               end else begin
                  adv_in   = 1'b0;
                  cur_in   = req_seq[sdw_pkg::SEQ_W-1:sdw_pkg::BIT_IDX_W];
                  state_in = sdw_pkg::ST_READ;
               end
            end
         end
         sdw_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = sdw_pkg::ST_MODIFY;
         end
         sdw_pkg::ST_MODIFY: begin
            ram_wr_en = 1'b1;
            if (last_word) begin
               verdict_in = (adv_ff || !hit) ? sdw_pkg::VERDICT_ACCEPT
                                             : sdw_pkg::VERDICT_DUPLICATE;
               state_in   = sdw_pkg::ST_DONE;
            end else begin
               cur_in   = cur_ff + sdw_pkg::BLK_W'(1);
               first_in = 1'b0;
               state_in = sdw_pkg::ST_READ;
            end
         end
         sdw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               state_in       = sdw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdw_pkg::ST_CLEAR;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sweep_ff     <= '0;
         jump_ff      <= 1'b0;
         top_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         sweep_ff     <= sweep_in;
         jump_ff      <= jump_in;
         top_ff       <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff         <= seq_in;
      cur_ff         <= cur_in;
      tb_ff          <= tb_in;
      adv_ff         <= adv_in;
      first_ff       <= first_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   sdw_ram #(
      .WIDTH  (sdw_pkg::WORD_W),
      .DEPTH  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == sdw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sdw_pkg::RSP_TDATA_W-2){1'b0}}, rsp_verdict_ff};

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // bitmap only written while a request or the reset pass is being worked
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdw_pkg::ST_IDLE || state_ff == sdw_pkg::ST_DONE) |-> !ram_wr_en)
      else $error("bitmap written outside a request");

   // once started, stays started until reset
   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped");

   // a finished verdict never overwrites one still waiting
   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdw_pkg::ST_DONE && rsp_valid_ff && !rsp_tready)
         |=> state_ff == sdw_pkg::ST_DONE)
      else $error("verdict loaded over a pending response");

endmodule

// ===== rtl/sdw_ram.sv =====
module sdw_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
